// ----- src/sahist_pkg.sv -----
`default_nettype none

package sahist_pkg;

    localparam int TEMP_W    = 16;
    localparam int HUM_W     = 15;
    localparam int RAIN_W    = 9;
    localparam int IDX_W     = 8;
    localparam int NIB_W     = 4;
    localparam int WPOS_W    = 7;
    localparam int WEIGHT_W  = 8;
    localparam int CFG_IDX_W = 1;

    // rain code is bits [6:3] of the rain chance
    localparam int RAIN_CODE_LSB = 3;

    // iterative divider, one per average: 24-bit magnitude over a divisor of 1..256
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_CNT_W = 5;

    // fixed-point reciprocal used to split a read index into word and lane
    localparam int RECIP_SHIFT = 16;

    typedef enum logic
    {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_TEMP_WEIGHT     = 1'b0,
        REG_HUMIDITY_WEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        opcode_t                    opcode;
        logic signed [TEMP_W-1:0]   temp_sample;
        logic [HUM_W-1:0]           humidity_sample;
        logic [RAIN_W-1:0]          rain_chance;
        logic                       sample_invalid;
        logic [IDX_W-1:0]           point_index;
    } sahist_in_t;

    typedef struct packed
    {
        logic signed [TEMP_W-1:0]   temp_average;
        logic [HUM_W-1:0]           humidity_average;
        logic [NIB_W-1:0]           point_value;
        logic [WPOS_W-1:0]          write_position;
        logic                       rejected;
    } sahist_out_t;

endpackage

`default_nettype wire

// ----- src/sahist_chan_if.sv -----
`default_nettype none

interface sahist_chan_if #(parameter type payload_t = logic) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

// ----- src/sensor_average_and_rain_history.sv -----
`default_nettype none

// Channel    Role    Carries
// sample     sink    one add or read request per transaction
// result     source  averages, history nibble, write slot, reject flag
// cfg_*      write   temp_weight (index 0), humidity_weight (index 1)
//
// An accepted add multiplies, then runs the two bit-serial dividers (one quotient
// bit per numerator bit), takes the quotients and loads the output; sample.ready
// rises again with the output load.
// A read loads its result after the RAM read and lane select; a rejected add goes
// straight to the output load. After reset a clearing pass zeroes the RAM word by
// word; sample.ready stays low until it ends.
// A result held by a stalled sink does not stop the next item from starting.

module sensor_average_and_rain_history #(
    parameter int HISTORY_DEPTH    = 128,
    parameter int NIBBLES_PER_WORD = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sahist_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sahist_pkg::WEIGHT_W-1:0]     cfg_data,
    sahist_chan_if.sink                         sample,
    sahist_chan_if.source                       result
);

    import sahist_pkg::*;

    localparam int WORD_W     = NIBBLES_PER_WORD * NIB_W;
    localparam int WORD_COUNT = (HISTORY_DEPTH + NIBBLES_PER_WORD - 1) / NIBBLES_PER_WORD;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PTR_W      = $clog2(HISTORY_DEPTH);
    localparam int LANE_W     = (NIBBLES_PER_WORD > 1) ? $clog2(NIBBLES_PER_WORD) : 1;
    localparam int RECIP      = (2 ** RECIP_SHIFT + NIBBLES_PER_WORD - 1) / NIBBLES_PER_WORD;
    localparam int RECIP_W    = RECIP_SHIFT + 1;
    localparam int PROD_W     = IDX_W + RECIP_W;
    localparam int TNUM_W     = TEMP_W + WEIGHT_W + 1;

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_RD   = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [WEIGHT_W-1:0]        tw_reg;
    logic [WEIGHT_W-1:0]        tw_next;
    logic [WEIGHT_W-1:0]        hw_reg;
    logic [WEIGHT_W-1:0]        hw_next;
    logic signed [TEMP_W-1:0]   tavg_reg;
    logic signed [TEMP_W-1:0]   tavg_next;
    logic [HUM_W-1:0]           havg_reg;
    logic [HUM_W-1:0]           havg_next;
    logic [PTR_W-1:0]           ptr_reg;
    logic [PTR_W-1:0]           ptr_next;
    logic [AW-1:0]              wr_word_reg;
    logic [AW-1:0]              wr_word_next;
    logic [LANE_W-1:0]          wr_lane_reg;
    logic [LANE_W-1:0]          wr_lane_next;
    sahist_in_t                 in_reg;
    sahist_in_t                 in_next;
    logic [IDX_W-1:0]           rd_word_reg;
    logic [IDX_W-1:0]           rd_word_next;
    logic                       rd_ok_reg;
    logic                       rd_ok_next;
    logic [NIB_W-1:0]           point_reg;
    logic [NIB_W-1:0]           point_next;
    logic                       rej_reg;
    logic                       rej_next;
    logic                       tneg_reg;
    logic                       tneg_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    sahist_out_t                out_data_reg;
    sahist_out_t                out_data_next;

    logic                       clr_busy;
    logic                       accept;
    logic [PROD_W-1:0]          idx_prod;
    logic [IDX_W-1:0]           idx_word;
    logic                       idx_ok;
    logic [AW-1:0]              rd_addr;
    logic [WORD_W-1:0]          rd_data;
    logic                       wr_en;
    logic [WORD_W-1:0]          word_merge;
    logic [NIB_W-1:0]           rain_code;
    logic [IDX_W-1:0]           lane_full;
    logic [LANE_W-1:0]          rd_lane;
    logic [NIB_W-1:0]           rd_nib;
    logic signed [TNUM_W-1:0]   tnum;
    logic [DIV_NUM_W-1:0]       tmag;
    logic [DIV_NUM_W-1:0]       hnum;
    logic [DIV_DEN_W-1:0]       tden;
    logic [DIV_DEN_W-1:0]       hden;
    logic                       div_start;
    logic                       t_done;
    logic                       h_done;
    logic [DIV_NUM_W-1:0]       t_quo;
    logic [DIV_NUM_W-1:0]       h_quo;

    assign sample.ready = (state_reg == ST_IDLE) && !clr_busy;
    assign accept       = sample.valid && sample.ready;

    // word = index * ceil(2^16 / N) >> 16, exact for 8-bit indexes
    assign idx_prod = sample.data.point_index * RECIP_W'(RECIP);
    assign idx_word = idx_prod[RECIP_SHIFT +: IDX_W];
    assign idx_ok   = (32'(sample.data.point_index) < HISTORY_DEPTH);

    always_comb
    begin
        if (sample.data.opcode == OP_READ)
        begin
            rd_addr = idx_ok ? AW'(idx_word) : '0;
        end
        else
        begin
            rd_addr = wr_word_reg;
        end
    end

    // replace one lane of the fetched word with the new rain code
    assign rain_code = in_reg.rain_chance[RAIN_CODE_LSB +: NIB_W];

    always_comb
    begin
        for (int l = 0; l < NIBBLES_PER_WORD; l++)
        begin
            word_merge[l*NIB_W +: NIB_W] = (LANE_W'(l) == wr_lane_reg) ?
                                           rain_code : rd_data[l*NIB_W +: NIB_W];
        end
    end

    assign lane_full = in_reg.point_index - IDX_W'(rd_word_reg * NIBBLES_PER_WORD);
    assign rd_lane   = LANE_W'(lane_full);

    always_comb
    begin
        rd_nib = '0;
        for (int l = 0; l < NIBBLES_PER_WORD; l++)
        begin
            if (LANE_W'(l) == rd_lane)
            begin
                rd_nib = rd_data[l*NIB_W +: NIB_W];
            end
        end
    end

    // numerators and divisors, fed straight into the dividers on start
    assign tnum = tavg_reg * $signed({1'b0, tw_reg}) + in_reg.temp_sample;
    assign tmag = tnum[TNUM_W-1] ? DIV_NUM_W'(-tnum) : DIV_NUM_W'(tnum);
    assign hnum = havg_reg * hw_reg + DIV_NUM_W'(in_reg.humidity_sample);
    assign tden = {1'b0, tw_reg} + DIV_DEN_W'(1);
    assign hden = {1'b0, hw_reg} + DIV_DEN_W'(1);

    assign wr_en     = (state_reg == ST_MUL);
    assign div_start = (state_reg == ST_MUL);

    always_comb
    begin
        tw_next = tw_reg;
        hw_next = hw_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMP_WEIGHT:     tw_next = cfg_data;
                REG_HUMIDITY_WEIGHT: hw_next = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tavg_next      = tavg_reg;
        havg_next      = havg_reg;
        ptr_next       = ptr_reg;
        wr_word_next   = wr_word_reg;
        wr_lane_next   = wr_lane_reg;
        in_next        = in_reg;
        rd_word_next   = rd_word_reg;
        rd_ok_next     = rd_ok_reg;
        point_next     = point_reg;
        rej_next       = rej_reg;
        tneg_next      = tneg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // drop the held result once the sink takes it
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_next      = sample.data;
                    rd_word_next = idx_word;
                    rd_ok_next   = idx_ok;
                    point_next   = '0;
                    rej_next     = 1'b0;
                    if (sample.data.opcode == OP_READ)
                    begin
                        state_next = ST_RD;
                    end
                    else if (sample.data.sample_invalid)
                    begin
                        rej_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                tneg_next  = tnum[TNUM_W-1];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (t_done && h_done)
                begin
                    tavg_next = TEMP_W'(tneg_reg ? (~t_quo + 1'b1) : t_quo);
                    havg_next = HUM_W'(h_quo);
                    if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1))
                    begin
                        ptr_next     = '0;
                        wr_word_next = '0;
                        wr_lane_next = '0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                        if (wr_lane_reg == LANE_W'(NIBBLES_PER_WORD - 1))
                        begin
                            wr_lane_next = '0;
                            wr_word_next = wr_word_reg + 1'b1;
                        end
                        else
                        begin
                            wr_lane_next = wr_lane_reg + 1'b1;
                        end
                    end
                    state_next = ST_FIN;
                end
            end
            ST_RD:
            begin
                point_next = rd_ok_reg ? rd_nib : '0;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.temp_average     = tavg_reg;
                    out_data_next.humidity_average = havg_reg;
                    out_data_next.point_value      = point_reg;
                    out_data_next.write_position   = WPOS_W'(ptr_reg);
                    out_data_next.rejected         = rej_reg;
                    state_next                     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tw_reg        <= '0;
            hw_reg        <= '0;
            tavg_reg      <= '0;
            havg_reg      <= '0;
            ptr_reg       <= '0;
            wr_word_reg   <= '0;
            wr_lane_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tw_reg        <= tw_next;
            hw_reg        <= hw_next;
            tavg_reg      <= tavg_next;
            havg_reg      <= havg_next;
            ptr_reg       <= ptr_next;
            wr_word_reg   <= wr_word_next;
            wr_lane_reg   <= wr_lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        rd_word_reg  <= rd_word_next;
        rd_ok_reg    <= rd_ok_next;
        point_reg    <= point_next;
        rej_reg      <= rej_next;
        tneg_reg     <= tneg_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    sahist_ring #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_W     (WORD_W),
        .AW         (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_word_reg),
        .wr_data (word_merge),
        .rd_data (rd_data),
        .busy    (clr_busy)
    );

    sahist_div u_tdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (tmag),
        .den   (tden),
        .done  (t_done),
        .quo   (t_quo)
    );

    sahist_div u_hdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (hnum),
        .den   (hden),
        .done  (h_done),
        .quo   (h_quo)
    );

endmodule

`default_nettype wire

// ----- src/sahist_div.sv -----
`default_nettype none

module sahist_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sahist_pkg::DIV_NUM_W-1:0] num,
    input  logic [sahist_pkg::DIV_DEN_W-1:0] den,
    output logic                            done,
    output logic [sahist_pkg::DIV_NUM_W-1:0] quo
);

    import sahist_pkg::*;

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic [DIV_DEN_W-1:0]   rem_reg;
    logic [DIV_DEN_W-1:0]   rem_next;
    logic [DIV_NUM_W-1:0]   quo_reg;
    logic [DIV_NUM_W-1:0]   quo_next;
    logic [DIV_DEN_W-1:0]   den_reg;
    logic [DIV_DEN_W-1:0]   den_next;
    logic [DIV_DEN_W:0]     rem_sh;
    logic                   fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        fits      = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : DIV_DEN_W'(rem_sh);
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- src/sahist_ring.sv -----
`default_nettype none

module sahist_ring #(
    parameter int WORD_COUNT = 16,
    parameter int WORD_W     = 32,
    parameter int AW         = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    output logic [WORD_W-1:0] rd_data,
    output logic              busy
);

    logic [WORD_W-1:0] mem [WORD_COUNT];
    logic [WORD_W-1:0] rd_data_reg;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;

    // sweep every word to zero after reset
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            if (clr_cnt_reg == AW'(WORD_COUNT - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

// ----- src/sahist_chk.sv -----
`default_nettype none

module sahist_chk
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  sahist_pkg::sahist_out_t out_data
);

    import sahist_pkg::*;

    // one item at a time: ready drops after every accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("sahist: input accepted in back-to-back cycles");

    // a result never appears in the cycle straight after an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("sahist: result appeared too early");

    // a rejected add carries no history nibble
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rejected |-> out_data.point_value == '0)
    else $error("sahist: rejected result with nonzero point value");

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("sahist: stalled result changed or dropped");

endmodule

bind sensor_average_and_rain_history sahist_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

`default_nettype wire

// ----- dv/tb_sensor_average_and_rain_history.sv -----
`timescale 1ns / 100ps

module tb_sensor_average_and_rain_history;

    import sahist_pkg::*;

    localparam int HISTORY_DEPTH  = 128;
    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 200;
    localparam int PHASES         = 6;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 40;

    class weather_scoreboard;
        logic [WEIGHT_W-1:0]      temp_w;
        logic [WEIGHT_W-1:0]      hum_w;
        logic signed [TEMP_W-1:0] temp_avg;
        logic [HUM_W-1:0]         hum_avg;
        logic [NIB_W-1:0]         rain_ring [HISTORY_DEPTH];
        logic [WPOS_W-1:0]        wr_ptr;
        sahist_out_t              due_outputs [$];
        int                       mismatches;

        function new();
            temp_w     = '0;
            hum_w      = '0;
            temp_avg   = '0;
            hum_avg    = '0;
            wr_ptr     = '0;
            mismatches = 0;
            foreach (rain_ring[i])
                rain_ring[i] = '0;
        endfunction

        function void set_weight(cfg_reg_t which, logic [WEIGHT_W-1:0] value);
            if (which == REG_TEMP_WEIGHT)
                temp_w = value;
            else
                hum_w = value;
        endfunction

        // Advance the averages and the ring for one accepted transaction.
        function void note_sample(sahist_in_t s);
            sahist_out_t o;
            int          ta;
            int          tw;
            int          ts;
            int          tnum;
            int unsigned ha;
            int unsigned hw;
            int unsigned hs;
            int unsigned hnum;

            o.point_value = '0;
            o.rejected    = 1'b0;
            if (s.opcode == OP_ADD)
            begin
                if (s.sample_invalid)
                begin
                    o.rejected = 1'b1;
                end
                else
                begin
                    ta       = temp_avg;
                    tw       = temp_w;
                    ts       = s.temp_sample;
                    tnum     = ta * tw + ts;
                    temp_avg = 16'(tnum / (tw + 1));
                    ha       = hum_avg;
                    hw       = hum_w;
                    hs       = s.humidity_sample;
                    hnum     = ha * hw + hs;
                    hum_avg  = 15'(hnum / (hw + 1));
                    rain_ring[wr_ptr] = s.rain_chance[RAIN_CODE_LSB +: NIB_W];
                    wr_ptr   = wr_ptr + 1'b1;
                end
            end
            else if (s.point_index < HISTORY_DEPTH)
            begin
                o.point_value = rain_ring[s.point_index];
            end
            o.temp_average     = temp_avg;
            o.humidity_average = hum_avg;
            o.write_position   = wr_ptr;
            due_outputs.push_back(o);
        endfunction

        function void check_output(sahist_out_t got);
            sahist_out_t want;

            if (due_outputs.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: temp %0d hum %0d point %0d wpos %0d rej %0b",
                             got.temp_average, got.humidity_average, got.point_value,
                             got.write_position, got.rejected);
                mismatches++;
                return;
            end
            want = due_outputs.pop_front();
            if (got.temp_average !== want.temp_average
                || got.humidity_average !== want.humidity_average
                || got.point_value !== want.point_value
                || got.write_position !== want.write_position
                || got.rejected !== want.rejected)
            begin
                if (mismatches < 10)
                begin
                    $display("mismatch: exp temp %0d hum %0d point %0d wpos %0d rej %0b",
                             want.temp_average, want.humidity_average, want.point_value,
                             want.write_position, want.rejected);
                    $display("          got temp %0d hum %0d point %0d wpos %0d rej %0b",
                             got.temp_average, got.humidity_average, got.point_value,
                             got.write_position, got.rejected);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WEIGHT_W-1:0]  cfg_data;

    sahist_chan_if #(.payload_t(sahist_in_t))  sample_ch ();
    sahist_chan_if #(.payload_t(sahist_out_t)) result_ch ();

    weather_scoreboard sb;
    bit                long_hold_req;
    int                sender_calm;
    bit                quiet_tail;
    int                idle_cycles = 0;

    sensor_average_and_rain_history i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic sahist_in_t make_sample(opcode_t op, logic signed [TEMP_W-1:0] t,
                                               logic [HUM_W-1:0] h, logic [RAIN_W-1:0] r,
                                               logic inv, logic [IDX_W-1:0] idx);
        sahist_in_t s;

        s.opcode          = op;
        s.temp_sample     = t;
        s.humidity_sample = h;
        s.rain_chance     = r;
        s.sample_invalid  = inv;
        s.point_index     = idx;
        return s;
    endfunction

    function automatic sahist_in_t random_sample();
        sahist_in_t s;

        s.opcode = ($urandom_range(0, 9) < 6) ? OP_ADD : OP_READ;
        case ($urandom_range(0, 9))
            0:       s.temp_sample = 16'sh8000;
            1:       s.temp_sample = 16'sh7fff;
            default: s.temp_sample = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       s.humidity_sample = '0;
            1:       s.humidity_sample = 15'd25600;
            2:       s.humidity_sample = 15'($urandom_range(0, 32767));
            default: s.humidity_sample = 15'($urandom_range(0, 25600));
        endcase
        case ($urandom_range(0, 9))
            0:       s.rain_chance = 9'd256;
            1:       s.rain_chance = 9'($urandom_range(0, 511));
            default: s.rain_chance = 9'($urandom_range(0, 256));
        endcase
        s.sample_invalid = ($urandom_range(0, 9) == 0);
        s.point_index    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(128, 255))
                                                       : 8'($urandom_range(0, 127));
        return s;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so valid drops between offers only for a random gap.
    task automatic send_sample(input sahist_in_t s);
        int gap;

        if (!quiet_tail)
        begin
            if (sender_calm > 0)
            begin
                sender_calm--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 7);
                sample_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            else if ($urandom_range(0, 11) == 0)
            begin
                sender_calm = $urandom_range(20, 80);
            end
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_weight(input cfg_reg_t which, input logic [WEIGHT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        sb.set_weight(which, value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Result sink: random stall bursts, calm stretches, and one long hold-off.
    initial
    begin
        int stall_left;
        int run_left;
        int hold_left;
        bit hold_taken;

        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (quiet_tail)
            begin
                result_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                result_ch.ready <= 1'b1;
                run_left--;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 15);
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_output(result_ch.data);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready)
                || (result_ch.valid && result_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [WEIGHT_W-1:0] tw;
        logic [WEIGHT_W-1:0] hw;

        sb              = new();
        long_hold_req   = 1'b0;
        sender_calm     = 0;
        quiet_tail      = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_TEMP_WEIGHT;
        cfg_data        = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Cleared ring, reads inside and past the ring, extremes at weight zero.
        send_sample(make_sample(OP_READ, 16'sd0, 15'd0, 9'd0, 1'b0, 8'd0));
        send_sample(make_sample(OP_READ, 16'sd0, 15'd0, 9'd0, 1'b0, 8'd255));
        send_sample(make_sample(OP_ADD, 16'sh8000, 15'd0, 9'd256, 1'b0, 8'd0));
        send_sample(make_sample(OP_ADD, 16'sh7fff, 15'h7fff, 9'd255, 1'b0, 8'd255));
        send_sample(make_sample(OP_ADD, 16'sd1, 15'd25600, 9'd128, 1'b0, 8'd0));
        send_sample(make_sample(OP_ADD, -16'sd1, 15'd1, 9'd127, 1'b0, 8'd0));
        send_sample(make_sample(OP_ADD, 16'sh1234, 15'h5555, 9'h1ff, 1'b1, 8'haa));
        send_sample(make_sample(OP_READ, 16'sh7fff, 15'h7fff, 9'h1ff, 1'b1, 8'd1));
        send_sample(make_sample(OP_READ, 16'sd0, 15'd0, 9'd0, 1'b0, 8'd3));
        send_sample(make_sample(OP_READ, 16'sd0, 15'd0, 9'd0, 1'b0, 8'd127));
        send_sample(make_sample(OP_READ, 16'sd0, 15'd0, 9'd0, 1'b0, 8'd128));
        send_sample(make_sample(OP_READ, 16'sd0, 15'd0, 9'd0, 1'b0, 8'd2));
        drain_results();

        // Heavy weights: slow averages and negative truncation towards zero.
        write_weight(REG_TEMP_WEIGHT, 8'd255);
        write_weight(REG_HUMIDITY_WEIGHT, 8'd255);
        send_sample(make_sample(OP_ADD, 16'sh7fff, 15'h7fff, 9'd8, 1'b0, 8'd0));
        send_sample(make_sample(OP_ADD, 16'sh8000, 15'd0, 9'd120, 1'b0, 8'd0));
        send_sample(make_sample(OP_ADD, 16'sh8000, 15'd0, 9'd64, 1'b0, 8'd0));
        send_sample(make_sample(OP_ADD, 16'sh8000, 15'd25600, 9'd0, 1'b1, 8'd0));
        send_sample(make_sample(OP_READ, 16'sd0, 15'd0, 9'd0, 1'b0, 8'd5));
        send_sample(make_sample(OP_READ, 16'sd0, 15'd0, 9'd0, 1'b0, 8'd6));

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            tw = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : (p == 2) ? 8'd1
                                                      : 8'($urandom_range(0, 255));
            hw = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : (p == 2) ? 8'd254
                                                      : 8'($urandom_range(0, 255));
            write_weight(REG_TEMP_WEIGHT, tw);
            write_weight(REG_HUMIDITY_WEIGHT, hw);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Hold the sink off long enough for the block to back up.
                if (p == 2 && i == 40)
                    long_hold_req = 1'b1;
                if (p == PHASES - 1 && i == 50)
                    quiet_tail = 1'b1;
                send_sample(random_sample());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/sahist_pkg.sv
src/sahist_chan_if.sv
src/sahist_div.sv
src/sahist_ring.sv
src/sensor_average_and_rain_history.sv
src/sahist_chk.sv
dv/tb_sensor_average_and_rain_history.sv
